@@ hdl/fsmn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmn_pkg
// Shared constants and helpers for the binary32 datapath of the
// magic-seed square root block: leading-zero count and round/pack.
// ----------------------------------------------------------------------------
package fsmn_pkg;

    localparam logic [31:0] MAGIC_SEED      = 32'h5f3759df;
    localparam logic [31:0] CANON_NAN       = 32'h7FC00000;
    localparam logic [31:0] FP_HALF         = 32'h3F000000;
    localparam logic [31:0] FP_THREE_HALVES = 32'h3FC00000;
    localparam logic [7:0]  EXP_SPECIAL     = 8'hFF;
    localparam logic [33:0] PACK_OVERFLOW   = 34'h07F800000;

    typedef struct packed {
        logic nan;
        logic inf;
        logic zero;
        logic sign;
    } fp_flags_t;

    // Leading zeros of a 48-bit word; 48 when the word is zero.
    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       found;
        n     = 6'd48;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 6'(47 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // m holds the significand with the hidden-bit position at bit 47.
    // eenc is the biased exponent (1 for subnormals). Round to nearest even;
    // the carry out of the significand bumps the exponent field on its own.
    function automatic logic [31:0] round_pack(input logic sign,
                                               input logic signed [11:0] eenc,
                                               input logic [47:0] m,
                                               input logic st);
        logic [23:0] mant;
        logic        grd;
        logic        stk;
        logic        up;
        logic [24:0] sum;
        logic [11:0] em1;
        logic [33:0] pk;
        mant = m[47:24];
        grd  = m[23];
        stk  = (|m[22:0]) | st;
        up   = grd & (stk | mant[0]);
        sum  = {1'b0, mant} + {24'b0, up};
        em1  = 12'(eenc - 12'sd1);
        pk   = ({22'b0, em1} << 23) + {9'b0, sum};
        if (pk >= PACK_OVERFLOW) begin
            return {sign, EXP_SPECIAL, 23'b0};
        end
        return {sign, pk[30:0]};
    endfunction

endpackage

@@ hdl/fsmn_fmul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmn_fmul
// Three-stage binary32 multiplier: significand product, normalize with
// sticky, round and pack. Subnormals kept; NaN out is the canonical quiet NaN.
// ----------------------------------------------------------------------------
module fsmn_fmul (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [31:0] res
);
    import fsmn_pkg::*;

    logic [7:0]  ea, eb, eae, ebe;
    logic [23:0] ma, mb;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    fp_flags_t   flg_next;
    logic signed [11:0] e1_next;

    logic [47:0]        prod_reg;
    logic signed [11:0] e1_reg;
    fp_flags_t          flg1_reg;

    logic [5:0]         lz;
    logic               normal;
    logic signed [11:0] sl;
    logic signed [11:0] nsl;
    logic [6:0]         rsh;
    logic [95:0]        ext, shifted;

    logic [47:0]        m2_reg;
    logic               st2_reg;
    logic signed [11:0] eenc2_reg;
    fp_flags_t          flg2_reg;

    logic [31:0] res_next, res_reg;

    always_comb begin
        ea     = op_a[30:23];
        eb     = op_b[30:23];
        eae    = (ea == 8'd0) ? 8'd1 : ea;
        ebe    = (eb == 8'd0) ? 8'd1 : eb;
        ma     = {|ea, op_a[22:0]};
        mb     = {|eb, op_b[22:0]};
        nan_a  = (ea == EXP_SPECIAL) && (op_a[22:0] != 23'd0);
        nan_b  = (eb == EXP_SPECIAL) && (op_b[22:0] != 23'd0);
        inf_a  = (ea == EXP_SPECIAL) && (op_a[22:0] == 23'd0);
        inf_b  = (eb == EXP_SPECIAL) && (op_b[22:0] == 23'd0);
        zero_a = (op_a[30:0] == 31'd0);
        zero_b = (op_b[30:0] == 31'd0);
        flg_next.nan  = nan_a | nan_b | (inf_a & zero_b) | (inf_b & zero_a);
        flg_next.inf  = inf_a | inf_b;
        flg_next.zero = zero_a | zero_b;
        flg_next.sign = op_a[31] ^ op_b[31];
        e1_next = $signed({4'b0, eae}) + $signed({4'b0, ebe}) - 12'sd127;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= ma * mb;
            e1_reg   <= e1_next;
            flg1_reg <= flg_next;
        end
    end

    // Normalize: leading one to bit 47, or clamp to the subnormal exponent.
    always_comb begin
        lz     = lzc48(prod_reg);
        normal = $signed({6'b0, lz}) <= e1_reg;
        sl     = normal ? $signed({6'b0, lz}) : e1_reg;
        nsl    = -sl;
        // beyond 50 places everything lands in the sticky bit
        rsh    = (nsl > 12'sd50) ? 7'd50 : nsl[6:0];
        ext    = {prod_reg, 48'b0};
        if (sl >= 12'sd0) begin
            shifted = ext << sl[5:0];
        end else begin
            shifted = ext >> rsh;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m2_reg    <= shifted[95:48];
            st2_reg   <= |shifted[47:0];
            eenc2_reg <= e1_reg - sl + 12'sd1;
            flg2_reg  <= flg1_reg;
        end
    end

    always_comb begin
        if (flg2_reg.nan) begin
            res_next = CANON_NAN;
        end else if (flg2_reg.inf) begin
            res_next = {flg2_reg.sign, EXP_SPECIAL, 23'b0};
        end else if (flg2_reg.zero) begin
            res_next = {flg2_reg.sign, 31'b0};
        end else begin
            res_next = round_pack(flg2_reg.sign, eenc2_reg, m2_reg, st2_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

@@ hdl/fsmn_fadd.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmn_fadd
// Three-stage binary32 adder: swap and align with guard/round/sticky,
// add or subtract with leading-zero count, normalize, round and pack.
// ----------------------------------------------------------------------------
module fsmn_fadd (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [31:0] res
);
    import fsmn_pkg::*;

    logic        a_big;
    logic [31:0] big, sml;
    logic [7:0]  eb_e, es_e, d;
    logic [23:0] mbig, msml;
    logic [26:0] sm_ext, sm_sh, sm_mask, aligned;
    logic        nan_a, nan_b, inf_a, inf_b;
    fp_flags_t   flg_next;

    logic [26:0] big_reg, sm_reg;
    logic        sub_reg, zsign_reg;
    logic [7:0]  eb_reg;
    fp_flags_t   flg1_reg;

    logic [27:0] sum;
    logic [47:0] m_next;

    logic [47:0] m2_reg;
    logic [5:0]  lz2_reg;
    logic [7:0]  eb2_reg;
    logic        zsign2_reg;
    fp_flags_t   flg2_reg;

    logic signed [11:0] e, sl;
    logic               normal;
    logic [47:0]        shifted;
    logic [31:0]        res_next, res_reg;

    always_comb begin
        a_big   = op_a[30:0] >= op_b[30:0];
        big     = a_big ? op_a : op_b;
        sml     = a_big ? op_b : op_a;
        eb_e    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es_e    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        mbig    = {|big[30:23], big[22:0]};
        msml    = {|sml[30:23], sml[22:0]};
        d       = eb_e - es_e;
        sm_ext  = {msml, 3'b0};
        sm_sh   = sm_ext >> d[4:0];
        sm_mask = (27'd1 << d[4:0]) - 27'd1;
        if (d >= 8'd27) begin
            aligned = {26'b0, |msml};
        end else begin
            aligned = {sm_sh[26:1], sm_sh[0] | (|(sm_ext & sm_mask))};
        end
        nan_a = (op_a[30:23] == EXP_SPECIAL) && (op_a[22:0] != 23'd0);
        nan_b = (op_b[30:23] == EXP_SPECIAL) && (op_b[22:0] != 23'd0);
        inf_a = (op_a[30:23] == EXP_SPECIAL) && (op_a[22:0] == 23'd0);
        inf_b = (op_b[30:23] == EXP_SPECIAL) && (op_b[22:0] == 23'd0);
        flg_next.nan  = nan_a | nan_b | (inf_a & inf_b & (op_a[31] ^ op_b[31]));
        flg_next.inf  = inf_a | inf_b;
        flg_next.zero = 1'b0;
        // the larger magnitude carries the sign, also for an infinity
        flg_next.sign = big[31];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            big_reg   <= {mbig, 3'b0};
            sm_reg    <= aligned;
            sub_reg   <= op_a[31] ^ op_b[31];
            zsign_reg <= op_a[31] & op_b[31];
            eb_reg    <= eb_e;
            flg1_reg  <= flg_next;
        end
    end

    always_comb begin
        if (sub_reg) begin
            sum = {1'b0, big_reg} - {1'b0, sm_reg};
        end else begin
            sum = {1'b0, big_reg} + {1'b0, sm_reg};
        end
        m_next = {sum, 20'b0};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m2_reg     <= m_next;
            lz2_reg    <= lzc48(m_next);
            eb2_reg    <= eb_reg;
            zsign2_reg <= zsign_reg;
            flg2_reg   <= flg1_reg;
        end
    end

    always_comb begin
        e       = $signed({4'b0, eb2_reg});
        normal  = $signed({6'b0, lz2_reg}) <= e;
        sl      = normal ? $signed({6'b0, lz2_reg}) : e;
        shifted = m2_reg << sl[5:0];
        if (flg2_reg.nan) begin
            res_next = CANON_NAN;
        end else if (flg2_reg.inf) begin
            res_next = {flg2_reg.sign, EXP_SPECIAL, 23'b0};
        end else if (m2_reg == 48'd0) begin
            // exact cancellation gives +0; two like-signed zeros keep the sign
            res_next = {zsign2_reg, 31'b0};
        end else begin
            res_next = round_pack(flg2_reg.sign, e - sl + 12'sd1, shifted, 1'b0);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

@@ hdl/fast_sqrt_magic_newton.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_sqrt_magic_newton
// Approximate binary32 square root from a magic-number seed and one
// Newton step, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock while the pipeline advances, and returns
// one result per transaction, in order. The pipeline is the input register
// plus five chained 3-stage float units (h*y, *y, 1.5-b, a*c after the first
// x*0.5 / x*y pair). The whole pipeline advances whenever the output register
// is empty or being taken; s_tready follows that condition combinationally.
// A NaN result always comes out as 0x7FC00000.
module fast_sqrt_magic_newton (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] x_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] root_bits
);
    import fsmn_pkg::*;

    localparam int UNIT_LAT = 3;
    localparam int PIPE_LEN = 1 + 5 * UNIT_LAT;

    logic        adv;
    logic [31:0] x0_reg, y0_reg;
    logic [31:0] y_dly_reg [0:2*UNIT_LAT-1];
    logic [31:0] a_dly_reg [0:3*UNIT_LAT-1];
    logic [PIPE_LEN-1:0] vld_reg;

    logic [31:0] h, a, hy, b, c, r;

    assign adv      = !vld_reg[PIPE_LEN-1] || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_LEN-2:0], s_tvalid};
        end
    end

    // seed: magic constant minus the input shifted right with sign kept
    always_ff @(posedge aclk) begin
        if (adv) begin
            x0_reg <= s_tdata;
            y0_reg <= MAGIC_SEED - {s_tdata[31], s_tdata[31:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            y_dly_reg[0] <= y0_reg;
            for (int i = 1; i < 2 * UNIT_LAT; i++) begin
                y_dly_reg[i] <= y_dly_reg[i-1];
            end
            a_dly_reg[0] <= a;
            for (int i = 1; i < 3 * UNIT_LAT; i++) begin
                a_dly_reg[i] <= a_dly_reg[i-1];
            end
        end
    end

    fsmn_fmul u_mul_h (.aclk(aclk), .en(adv), .op_a(FP_HALF), .op_b(x0_reg), .res(h));
    fsmn_fmul u_mul_a (.aclk(aclk), .en(adv), .op_a(x0_reg), .op_b(y0_reg), .res(a));
    fsmn_fmul u_mul_hy (
        .aclk(aclk), .en(adv), .op_a(h), .op_b(y_dly_reg[UNIT_LAT-1]), .res(hy)
    );
    fsmn_fmul u_mul_b (
        .aclk(aclk), .en(adv), .op_a(hy), .op_b(y_dly_reg[2*UNIT_LAT-1]), .res(b)
    );
    fsmn_fadd u_sub_c (
        .aclk(aclk), .en(adv), .op_a(FP_THREE_HALVES), .op_b({~b[31], b[30:0]}), .res(c)
    );
    fsmn_fmul u_mul_r (
        .aclk(aclk), .en(adv), .op_a(a_dly_reg[3*UNIT_LAT-1]), .op_b(c), .res(r)
    );

    assign m_tvalid = vld_reg[PIPE_LEN-1];
    assign m_tdata  = r;

endmodule

@@ hdl/fsmn_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmn_checker
// Port-level checks for the square root pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module fsmn_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // input side takes a transaction whenever the output can move
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not track output flow");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_nan_canon: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[30:23] == 8'hFF && m_tdata[22:0] != 23'd0
        |-> m_tdata == 32'h7FC00000)
        else $error("non-canonical NaN result");

    a_in_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid |-> !$isunknown(s_tdata))
        else $error("unknown bits in an offered transaction");

endmodule

bind fast_sqrt_magic_newton fsmn_checker u_fsmn_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the magic-seed square root block. A bit-exact binary32
// predictor builds the expected root for each accepted x. Results are checked
// in order against those predictions. Both sides idle at random, and one
// phase holds the output off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb;
    import fsmn_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] x_bits
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] root_bits

    logic [31:0] root_queue[$];
    int          mismatches;
    int          idle_cycles;
    bit          hold_output;
    bit          out_gaps_on;

    fast_sqrt_magic_newton dut (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // binary32 bits -> double (exact)
    function automatic real f32_to_real(input logic [31:0] b);
        logic [23:0] m;
        int          e;
        m = {1'b1, b[22:0]};
        e = int'(b[30:23]) - 127;
        if (b[30:23] == 8'hFF)
            return $bitstoreal({b[31], 11'h7FF, b[22:0], 29'b0});
        if (b[30:0] == 31'b0)
            return $bitstoreal({b[31], 63'b0});
        if (b[30:23] == 8'h00) begin
            m = {1'b0, b[22:0]};
            e = -126;
            while (!m[23]) begin
                m = m << 1;
                e--;
            end
        end
        return $bitstoreal({b[31], 11'(e + 1023), m[22:0], 29'b0});
    endfunction

    // double -> binary32, round to nearest even, subnormals kept
    function automatic logic [31:0] real_to_f32(input real r);
        logic [63:0] d;
        logic [63:0] m;
        logic [63:0] kept;
        logic [63:0] packed_bits;
        logic        grd;
        logic        sticky;
        int          e;
        int          sh;
        d = $realtobits(r);
        if (d[62:52] == 11'h7FF)
            return (d[51:0] != 0) ? CANON_NAN : {d[63], EXP_SPECIAL, 23'b0};
        if (d[62:52] == 11'h000)
            return {d[63], 31'b0};
        e  = int'(d[62:52]) - 1023;
        m  = {11'b1, d[51:0]};
        sh = 29 + ((e < -126) ? (-126 - e) : 0);
        if (sh > 60)
            return {d[63], 31'b0};
        kept   = m >> sh;
        grd    = m[sh-1];
        sticky = (m & ((64'd1 << (sh - 1)) - 64'd1)) != 0;
        if (grd && (sticky || kept[0]))
            kept++;
        // hidden bit of kept lifts the exponent field by one; carry does the same
        packed_bits = ((e >= -126) ? (64'(e + 126) << 23) : 64'd0) + kept;
        if (packed_bits >= 64'h7F800000)
            return {d[63], EXP_SPECIAL, 23'b0};
        return {d[63], packed_bits[30:0]};
    endfunction

    function automatic logic [31:0] predict_root(input logic [31:0] xb);
        logic [31:0] seed;
        logic [31:0] h, a, hy, b, c;
        real         x, y, bv;
        seed = MAGIC_SEED - {xb[31], xb[31:1]};
        x  = f32_to_real(xb);
        y  = f32_to_real(seed);
        h  = real_to_f32(0.5 * x);
        a  = real_to_f32(x * y);
        hy = real_to_f32(f32_to_real(h) * y);
        b  = real_to_f32(f32_to_real(hy) * y);
        bv = f32_to_real(b);
        // below an eighth of an ulp of 1.5 (2^-26) the difference is 1.5; above that the
        // double subtraction is exact
        if (b[30:0] != 0 && b[30:23] != 8'hFF && (bv < 0 ? -bv : bv) < 2.0 ** -26)
            c = FP_THREE_HALVES;
        else
            c = real_to_f32(1.5 - bv);
        return real_to_f32(f32_to_real(a) * f32_to_real(c));
    endfunction

    task automatic send_x(input logic [31:0] xb);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= xb;
        do @(posedge aclk); while (!s_tready);
        root_queue.push_back(predict_root(xb));
    endtask

    // receiver: random stalls, or a long hold-off when asked
    initial begin
        int wait_cycles;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_output) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_output = 1'b0;
            end
            wait_cycles = out_gaps_on ? $urandom_range(0, 6) : 0;
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        logic [31:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (root_queue.size() == 0) begin
                $error("root_bits: unexpected result %h", m_tdata);
                mismatches++;
            end else begin
                want = root_queue.pop_front();
                if (m_tdata !== want) begin
                    $error("root_bits: expected %h actual %h", want, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_directed();
        logic [31:0] corner_x[$];
        corner_x = '{32'h00000000, 32'h80000000, 32'h3F800000, 32'h40800000,
                     32'h40000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
                     32'h7FFFFFFF, 32'hFFFFFFFF, 32'h00000001, 32'h007FFFFF,
                     32'h00800000, 32'h7F7FFFFF, 32'hBF800000, 32'h55555555,
                     32'hAAAAAAAA, 32'h3F000000, 32'h80000001, 32'h42C80000};
        foreach (corner_x[i])
            send_x(corner_x[i]);
    endtask

    task automatic test_random(input int count);
        logic [31:0] xb;
        repeat (count) begin
            case ($urandom_range(0, 3))
                0: xb = $urandom();
                // positive normals in a moderate range: the useful domain
                default: xb = {1'b0, 8'($urandom_range(60, 194)), 23'($urandom())};
            endcase
            send_x(xb);
        end
    endtask

    task automatic test_backpressure();
        hold_output = 1'b1;
        test_random(60);
    endtask

    initial begin
        mismatches  = 0;
        idle_cycles = 0;
        hold_output = 1'b0;
        out_gaps_on = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(120);
        test_backpressure();
        out_gaps_on = 1'b1;
        test_random(220);
        s_tvalid <= 1'b0;
        while (root_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
